FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/lrsg_pkg.sv
// ----------------------------------------------------------------------------
// lrsg_pkg
// Widths, angle constants, arctangent table and shared types.
// ----------------------------------------------------------------------------
package lrsg_pkg;

    localparam int COORD_W         = 16;
    localparam int DIFF_W          = 17;
    localparam int MAG_W           = 16;
    localparam int SQ_W            = 32;
    localparam int HS_W            = 33;
    localparam int S_W             = 34;
    localparam int LVL_W           = 16;
    localparam int DIST_W          = 17;
    localparam int ELEV_W          = 15;
    localparam int ANG_W           = 16;
    localparam int CFG_IDX_W       = 2;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int TAB_FRAC        = 20;
    localparam int ANG_SHIFT       = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam int PRESHIFT        = 12;

    // square root and divider sizes
    localparam int S_M             = 17;
    localparam int H_M             = 25;
    localparam int Q_W             = 24;

    // CORDIC datapath
    localparam int CW              = 42;
    localparam int ZW              = 30;
    localparam int TAB_W           = 28;
    localparam int MAX_STAGES      = 32;

    localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180 << ANGLE_FRAC_BITS);
    localparam logic [ANG_W-1:0] DEG_270 = ANG_W'(270 << ANGLE_FRAC_BITS);
    localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360 << ANGLE_FRAC_BITS);
    localparam logic [ANG_W-1:0] DEG_450 = ANG_W'(450 << ANGLE_FRAC_BITS);

    localparam logic signed [ZW-1:0] Z_MAX      = ZW'(90 << TAB_FRAC);
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1 << (ANG_SHIFT - 1));

    // atan(2^-i) in units of 2^-20 degree
    localparam logic [TAB_W-1:0] ATAN_TAB [MAX_STAGES] = '{
        28'd47185920, 28'd27855475, 28'd14718068, 28'd7471121,
        28'd3750058,  28'd1876857,  28'd938658,   28'd469357,
        28'd234682,   28'd117342,   28'd58671,    28'd29335,
        28'd14668,    28'd7334,     28'd3667,     28'd1833,
        28'd917,      28'd458,      28'd229,      28'd115,
        28'd57,       28'd29,       28'd14,       28'd7,
        28'd4,        28'd2,        28'd1,        28'd0,
        28'd0,        28'd0,        28'd0,        28'd0
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LX     = 2'd0,
        CFG_LY     = 2'd1,
        CFG_LZ     = 2'd2,
        CFG_FACING = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic dx_zero;
        logic dx_neg;
        logic dy_zero;
        logic dy_neg;
        logic dz_zero;
        logic dz_neg;
    } t_flags;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [MAG_W-1:0] mz;
        t_flags           flags;
    } t_geo;

    typedef struct packed {
        logic   h_zero;
        t_flags flags;
    } t_late;

endpackage

FILE: sv/lrsg_src_if.sv
// ----------------------------------------------------------------------------
// lrsg_src_if
// Source position channel: valid, ready and one source beat.
// ----------------------------------------------------------------------------
interface lrsg_src_if;
    logic                                valid;
    logic                                ready;
    logic signed [lrsg_pkg::COORD_W-1:0] source_x;
    logic signed [lrsg_pkg::COORD_W-1:0] source_y;
    logic signed [lrsg_pkg::COORD_W-1:0] source_z;
    logic        [lrsg_pkg::LVL_W-1:0]   source_level;

    modport source (output valid, source_x, source_y, source_z, source_level,
                    input ready);
    modport sink   (input valid, source_x, source_y, source_z, source_level,
                    output ready);
endinterface

FILE: sv/lrsg_res_if.sv
// ----------------------------------------------------------------------------
// lrsg_res_if
// Result channel: valid, ready and one geometry result beat.
// ----------------------------------------------------------------------------
interface lrsg_res_if;
    logic                               valid;
    logic                               ready;
    logic        [lrsg_pkg::DIST_W-1:0] distance;
    logic signed [lrsg_pkg::ELEV_W-1:0] elevation;
    logic        [lrsg_pkg::ANG_W-1:0]  azimuth;
    logic        [lrsg_pkg::ANG_W-1:0]  left_azimuth;
    logic        [lrsg_pkg::ANG_W-1:0]  right_azimuth;
    logic        [lrsg_pkg::LVL_W-1:0]  heard_level;

    modport source (output valid, distance, elevation, azimuth, left_azimuth,
                    right_azimuth, heard_level, input ready);
    modport sink   (input valid, distance, elevation, azimuth, left_azimuth,
                    right_azimuth, heard_level, output ready);
endinterface

FILE: sv/lrsg_delay.sv
// ----------------------------------------------------------------------------
// lrsg_delay
// Stalling delay line; tap k loads when its stage advances.
// ----------------------------------------------------------------------------
module lrsg_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [N-1:0] i_adv,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q [N];

    for (genvar k = 0; k < N; k++) begin : g_tap
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_adv[k]) r_q[k] <= i_d;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_adv[k]) r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[N-1];
endmodule

FILE: sv/lrsg_isqrt.sv
// ----------------------------------------------------------------------------
// lrsg_isqrt
// Pipelined integer square root, one root bit per stage, with remainder.
// ----------------------------------------------------------------------------
module lrsg_isqrt #(
    parameter int M = 17
) (
    input  logic           i_clk,
    input  logic [M-1:0]   i_adv,
    input  logic [2*M-1:0] i_rad,
    output logic [M-1:0]   o_root,
    output logic [M+1:0]   o_rem
);
    logic [2*M-1:0] r_rad  [M];
    logic [M+1:0]   r_rem  [M];
    logic [M-1:0]   r_root [M];

    for (genvar k = 0; k < M; k++) begin : g_stage
        logic [2*M-1:0] p_rad;
        logic [M+1:0]   p_rem;
        logic [M-1:0]   p_root;
        logic [M+1:0]   w_tmp;
        logic [M+1:0]   w_trial;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_tmp   = {p_rem[M-1:0], p_rad[2*M-1 -: 2]};
        assign w_trial = {p_root, 2'b01};
        assign w_ge    = (w_tmp >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_adv[k]) begin
                r_rad[k]  <= {p_rad[2*M-3:0], 2'b00};
                r_rem[k]  <= w_ge ? (w_tmp - w_trial) : w_tmp;
                r_root[k] <= {p_root[M-2:0], w_ge};
            end
        end
    end

    assign o_root = r_root[M-1];
    assign o_rem  = r_rem[M-1];
endmodule

FILE: sv/lrsg_div.sv
// ----------------------------------------------------------------------------
// lrsg_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lrsg_div #(
    parameter int QW = 24,
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic [QW-1:0] i_adv,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    localparam int XW = QW + DW;

    logic [QW-1:0] r_num [QW];
    logic [QW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [QW-1:0] p_num;
        logic [QW-1:0] p_rem;
        logic [QW-1:0] p_quo;
        logic [DW-1:0] p_den;
        logic [QW-1:0] w_tmp;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign p_num = i_num;
            assign p_rem = '0;
            assign p_quo = '0;
            assign p_den = i_den;
        end else begin : g_next
            assign p_num = r_num[k-1];
            assign p_rem = r_rem[k-1];
            assign p_quo = r_quo[k-1];
            assign p_den = r_den[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign w_tmp = {p_rem[QW-2:0], p_num[QW-1]};
        assign w_ge  = (XW'(w_tmp) >= XW'(p_den));

        always_ff @(posedge i_clk) begin
            if (i_adv[k]) begin
                r_num[k] <= {p_num[QW-2:0], 1'b0};
                r_rem[k] <= w_ge ? (w_tmp - QW'(p_den)) : w_tmp;
                r_quo[k] <= {p_quo[QW-2:0], w_ge};
                r_den[k] <= p_den;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
endmodule

FILE: sv/lrsg_cordic.sv
// ----------------------------------------------------------------------------
// lrsg_cordic
// Pipelined CORDIC vectoring unit, one rotation per stage, angle out.
// ----------------------------------------------------------------------------
module lrsg_cordic #(
    parameter int NS = 16
) (
    input  logic                             i_clk,
    input  logic [NS-1:0]                    i_adv,
    input  logic signed [lrsg_pkg::CW-1:0]   i_x,
    input  logic signed [lrsg_pkg::CW-1:0]   i_y,
    output logic signed [lrsg_pkg::ZW-1:0]   o_z
);
    import lrsg_pkg::*;

    logic signed [CW-1:0] r_x [NS];
    logic signed [CW-1:0] r_y [NS];
    logic signed [ZW-1:0] r_z [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic signed [CW-1:0] p_x;
        logic signed [CW-1:0] p_y;
        logic signed [ZW-1:0] p_z;
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;
        logic signed [ZW-1:0] w_atan;

        if (k == 0) begin : g_first
            assign p_x = i_x;
            assign p_y = i_y;
            assign p_z = '0;
        end else begin : g_next
            assign p_x = r_x[k-1];
            assign p_y = r_y[k-1];
            assign p_z = r_z[k-1];
        end

        assign w_xs   = p_x >>> k;
        assign w_ys   = p_y >>> k;
        assign w_atan = ZW'(ATAN_TAB[k]);

        // rotate toward the x axis
        always_ff @(posedge i_clk) begin
            if (i_adv[k]) begin
                if (!p_y[CW-1]) begin
                    r_x[k] <= p_x + w_ys;
                    r_y[k] <= p_y - w_xs;
                    r_z[k] <= p_z + w_atan;
                end else begin
                    r_x[k] <= p_x - w_ys;
                    r_y[k] <= p_y + w_xs;
                    r_z[k] <= p_z - w_atan;
                end
            end
        end
    end

    assign o_z = r_z[NS-1];
endmodule

FILE: sv/listener_relative_source_geometry_core.sv
// ----------------------------------------------------------------------------
// listener_relative_source_geometry_core
// Source position to listener-relative distance, angles and heard level.
// ----------------------------------------------------------------------------
// Usage:
// - i_src carries one source beat (position Q12.4, level Q8.8); o_res returns
//   one result beat per source beat, in order: distance, elevation, azimuth,
//   left and right ear azimuths and the inverse-square heard level.
// - The listener position and bearing sit in four registers written through
//   i_cfg_we / i_cfg_idx / i_cfg_data; write them only while the pipe is empty.
// - Throughput: one beat per cycle while any stage is empty or o_res.ready
//   is high; the pipe holds 32 + CORDIC_STAGES beats. The depth is set by
//   four front stages, the 25-stage square root of the horizontal range,
//   the elevation CORDIC and three stages of rounding and angle wrap.
// - Every stage holds a valid bit; a stage advances when it is empty or the
//   stage after it advances, so bubbles are squeezed out while o_res stalls
//   and i_src.ready stays high until every stage holds a beat.
// - Reset clears all valid bits, puts the listener at the origin and the
//   bearing at 90 degrees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module listener_relative_source_geometry_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lrsg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lrsg_pkg::COORD_W-1:0]      i_cfg_data,
    lrsg_src_if.sink                          i_src,
    lrsg_res_if.source                        o_res
);
    import lrsg_pkg::*;

    localparam int NS      = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int ST_UNIT = 4;                    // first stage of the units
    localparam int ST_DR   = ST_UNIT + S_M;        // distance rounding
    localparam int ST_Q    = ST_UNIT + Q_W - 1;    // quotient out
    localparam int ST_HL   = ST_Q + 1;             // heard level clamp
    localparam int ST_H    = ST_UNIT + H_M - 1;    // horizontal root out
    localparam int ST_CE   = ST_H + NS;            // CORDIC out
    localparam int ST_PA   = ST_CE + 1;            // angle rounding
    localparam int ST_PB   = ST_CE + 2;            // quadrant and bearing
    localparam int ST_PC   = ST_CE + 3;            // output register
    localparam int D       = ST_PC + 1;
    localparam int AZW     = ANG_W + 3;

    localparam logic signed [AZW-1:0] FULL   = AZW'(DEG_360);
    localparam logic signed [AZW-1:0] FULL_2 = AZW'(2 * DEG_360);

    localparam logic signed [ELEV_W-1:0] ELEV_LIM = ELEV_W'(DEG_90);

    // configuration
    logic signed [COORD_W-1:0] r_lx, r_ly, r_lz;
    logic        [ANG_W-1:0]   r_facing;

    // flow control
    logic [D-1:0] r_vld, n_vld;
    logic [D:0]   w_adv;

    // front stages
    logic signed [DIFF_W-1:0] r0_dx, r0_dy, r0_dz;
    logic [LVL_W-1:0]         r0_lvl, r1_lvl, r2_lvl, r3_lvl;
    t_geo                     r1_geo;
    logic [SQ_W-1:0]          r2_mx2, r2_my2, r2_mz2;
    logic [HS_W-1:0]          r3_hs;
    logic [S_W-1:0]           r3_s;

    // unit outputs
    logic [S_M-1:0]   w_s_root;
    logic [S_M+1:0]   w_s_rem;
    logic [H_M-1:0]   w_h_root;
    logic [Q_W-1:0]   w_quo;
    logic [LVL_W-1:0] w_lvl_q;
    t_geo             w_geo_h;
    t_late            w_late;
    logic signed [ZW-1:0] w_el_z, w_az_z;

    logic [DIST_W-1:0] r_dist, w_dist_o;
    logic [LVL_W-1:0]  r_heard, w_heard_o;

    // angle stages
    logic [ANG_W-1:0]          r_pa_t;
    logic signed [ELEV_W-1:0]  r_pa_elev, r_pb_elev, r_o_elev;
    t_flags                    r_pa_flags;
    logic [ANG_W-1:0]          r_pb_az, r_o_az, r_o_left, r_o_right;

    logic [ANG_W-1:0]          w_e;
    logic signed [ELEV_W-1:0]  w_ev;
    logic [ANG_W-1:0]          w_ang;
    logic signed [AZW-1:0]     w_v;
    logic [ANG_W-1:0]          w_az;
    logic [ANG_W:0]            w_left, w_right;

    // output range checks
    logic                      w_az_ok;
    logic                      w_el_ok;

    // clamp to [0, 90 deg] and round to angle units
    function automatic logic [ANG_W-1:0] round_angle(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] zc;
        logic signed [ZW-1:0] zs;
        zc = z;
        if (z < 0) begin
            zc = '0;
        end else if (z > Z_MAX) begin
            zc = Z_MAX;
        end
        zs = zc + ROUND_HALF;
        return ANG_W'(zs >>> ANG_SHIFT);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx     <= '0;
            r_ly     <= '0;
            r_lz     <= '0;
            r_facing <= DEG_90;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LX:     r_lx     <= i_cfg_data;
                CFG_LY:     r_ly     <= i_cfg_data;
                CFG_LZ:     r_lz     <= i_cfg_data;
                CFG_FACING: r_facing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage advances when empty or when its successor does
    // ------------------------------------------------------------------
    assign w_adv[D] = o_res.ready;
    for (genvar k = 0; k < D; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end

    always_comb begin
        n_vld[0] = w_adv[0] ? i_src.valid : r_vld[0];
        for (int k = 1; k < D; k++) begin
            n_vld[k] = w_adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_src.ready = w_adv[0];

    // ------------------------------------------------------------------
    // Front: differences, magnitudes, squares, sums
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_dx  <= DIFF_W'(i_src.source_x) - DIFF_W'(r_lx);
            r0_dy  <= DIFF_W'(i_src.source_y) - DIFF_W'(r_ly);
            r0_dz  <= DIFF_W'(i_src.source_z) - DIFF_W'(r_lz);
            r0_lvl <= i_src.source_level;
        end
        if (w_adv[1]) begin
            r1_geo.mx            <= MAG_W'(r0_dx[DIFF_W-1] ? -r0_dx : r0_dx);
            r1_geo.my            <= MAG_W'(r0_dy[DIFF_W-1] ? -r0_dy : r0_dy);
            r1_geo.mz            <= MAG_W'(r0_dz[DIFF_W-1] ? -r0_dz : r0_dz);
            r1_geo.flags.dx_zero <= (r0_dx == '0);
            r1_geo.flags.dx_neg  <= r0_dx[DIFF_W-1];
            r1_geo.flags.dy_zero <= (r0_dy == '0);
            r1_geo.flags.dy_neg  <= r0_dy[DIFF_W-1];
            r1_geo.flags.dz_zero <= (r0_dz == '0);
            r1_geo.flags.dz_neg  <= r0_dz[DIFF_W-1];
            r1_lvl               <= r0_lvl;
        end
        if (w_adv[2]) begin
            r2_mx2 <= SQ_W'(r1_geo.mx) * SQ_W'(r1_geo.mx);
            r2_my2 <= SQ_W'(r1_geo.my) * SQ_W'(r1_geo.my);
            r2_mz2 <= SQ_W'(r1_geo.mz) * SQ_W'(r1_geo.mz);
            r2_lvl <= r1_lvl;
        end
        if (w_adv[3]) begin
            r3_hs  <= HS_W'(r2_mx2) + HS_W'(r2_mz2);
            r3_s   <= S_W'(r2_mx2) + S_W'(r2_my2) + S_W'(r2_mz2);
            r3_lvl <= r2_lvl;
        end
    end

    // ------------------------------------------------------------------
    // Distance: root of the squared range, round to nearest
    // ------------------------------------------------------------------
    lrsg_isqrt #(.M(S_M)) u_sqrt_s (
        .i_clk  (i_clk),
        .i_adv  (w_adv[ST_UNIT +: S_M]),
        .i_rad  (r3_s),
        .o_root (w_s_root),
        .o_rem  (w_s_rem)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_DR]) begin
            r_dist <= (w_s_rem > (S_M+2)'(w_s_root)) ? DIST_W'(w_s_root + 1'b1)
                                                      : DIST_W'(w_s_root);
        end
    end

    lrsg_delay #(.W(DIST_W), .N(ST_PC - ST_DR)) u_dly_dist (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_DR+1 +: ST_PC-ST_DR]),
        .i_d   (r_dist),
        .o_q   (w_dist_o)
    );

    // ------------------------------------------------------------------
    // Heard level: 256*L/S, capped at L; a zero range divides to all ones
    // ------------------------------------------------------------------
    lrsg_div #(.QW(Q_W), .DW(S_W)) u_div (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_UNIT +: Q_W]),
        .i_num ({r3_lvl, 8'h00}),
        .i_den (r3_s),
        .o_quo (w_quo)
    );

    lrsg_delay #(.W(LVL_W), .N(Q_W)) u_dly_lvl (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_UNIT +: Q_W]),
        .i_d   (r3_lvl),
        .o_q   (w_lvl_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_HL]) begin
            r_heard <= (w_quo > Q_W'(w_lvl_q)) ? w_lvl_q : LVL_W'(w_quo);
        end
    end

    lrsg_delay #(.W(LVL_W), .N(ST_PC - ST_HL)) u_dly_heard (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_HL+1 +: ST_PC-ST_HL]),
        .i_d   (r_heard),
        .o_q   (w_heard_o)
    );

    // ------------------------------------------------------------------
    // Horizontal range root, with magnitudes and signs carried alongside
    // ------------------------------------------------------------------
    lrsg_isqrt #(.M(H_M)) u_sqrt_h (
        .i_clk  (i_clk),
        .i_adv  (w_adv[ST_UNIT +: H_M]),
        .i_rad  ({1'b0, r3_hs, 16'h0000}),
        .o_root (w_h_root),
        .o_rem  ()
    );

    lrsg_delay #(.W($bits(t_geo)), .N(ST_H - 1)) u_dly_geo (
        .i_clk (i_clk),
        .i_adv (w_adv[2 +: ST_H-1]),
        .i_d   (r1_geo),
        .o_q   (w_geo_h)
    );

    // ------------------------------------------------------------------
    // Elevation and azimuth CORDICs run side by side
    // ------------------------------------------------------------------
    lrsg_cordic #(.NS(NS)) u_cordic_el (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_H+1 +: NS]),
        .i_x   (CW'({w_h_root, {PRESHIFT{1'b0}}})),
        .i_y   (CW'({w_geo_h.my, {(PRESHIFT+8){1'b0}}})),
        .o_z   (w_el_z)
    );

    lrsg_cordic #(.NS(NS)) u_cordic_az (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_H+1 +: NS]),
        .i_x   (CW'({w_geo_h.mx, {(PRESHIFT+8){1'b0}}})),
        .i_y   (CW'({w_geo_h.mz, {(PRESHIFT+8){1'b0}}})),
        .o_z   (w_az_z)
    );

    lrsg_delay #(.W($bits(t_late)), .N(NS)) u_dly_late (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_H+1 +: NS]),
        .i_d   ({(w_h_root == '0), w_geo_h.flags}),
        .o_q   (w_late)
    );

    // ------------------------------------------------------------------
    // Angle rounding; straight up or down gives 90 deg, dy zero gives 0
    // ------------------------------------------------------------------
    always_comb begin
        w_e  = w_late.h_zero ? DEG_90 : round_angle(w_el_z);
        w_ev = ELEV_W'(w_e);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_PA]) begin
            r_pa_t     <= round_angle(w_az_z);
            r_pa_flags <= w_late.flags;
            if (w_late.flags.dy_zero) begin
                r_pa_elev <= '0;
            end else begin
                r_pa_elev <= w_late.flags.dy_neg ? -w_ev : w_ev;
            end
        end
    end

    // ------------------------------------------------------------------
    // Quadrant rule, bearing offset, wrap into [0, 360 deg)
    // ------------------------------------------------------------------
    always_comb begin
        if (r_pa_flags.dx_zero) begin
            if (r_pa_flags.dz_zero) begin
                w_ang = '0;
            end else begin
                w_ang = r_pa_flags.dz_neg ? DEG_270 : DEG_90;
            end
        end else if (r_pa_flags.dz_zero) begin
            w_ang = r_pa_flags.dx_neg ? DEG_180 : '0;
        end else if (!r_pa_flags.dx_neg) begin
            w_ang = r_pa_flags.dz_neg ? (DEG_360 - r_pa_t) : r_pa_t;
        end else begin
            w_ang = r_pa_flags.dz_neg ? (DEG_180 + r_pa_t) : (DEG_180 - r_pa_t);
        end

        w_v = AZW'(w_ang) + AZW'(DEG_450) - AZW'(r_facing);
        if (w_v < 0) begin
            w_az = ANG_W'(w_v + FULL);
        end else if (w_v < FULL) begin
            w_az = ANG_W'(w_v);
        end else if (w_v < FULL_2) begin
            w_az = ANG_W'(w_v - FULL);
        end else begin
            w_az = ANG_W'(w_v - FULL_2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_PB]) begin
            r_pb_az   <= w_az;
            r_pb_elev <= r_pa_elev;
        end
    end

    // ------------------------------------------------------------------
    // Ear azimuths and output register
    // ------------------------------------------------------------------
    always_comb begin
        w_left  = (ANG_W+1)'(r_pb_az) + (ANG_W+1)'(DEG_270);
        w_right = (ANG_W+1)'(r_pb_az) + (ANG_W+1)'(DEG_90);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_PC]) begin
            r_o_az    <= r_pb_az;
            r_o_elev  <= r_pb_elev;
            r_o_left  <= (w_left  >= (ANG_W+1)'(DEG_360)) ?
                         ANG_W'(w_left  - (ANG_W+1)'(DEG_360)) : ANG_W'(w_left);
            r_o_right <= (w_right >= (ANG_W+1)'(DEG_360)) ?
                         ANG_W'(w_right - (ANG_W+1)'(DEG_360)) : ANG_W'(w_right);
        end
    end

    assign o_res.valid         = r_vld[ST_PC];
    assign o_res.distance      = w_dist_o;
    assign o_res.elevation     = r_o_elev;
    assign o_res.azimuth       = r_o_az;
    assign o_res.left_azimuth  = r_o_left;
    assign o_res.right_azimuth = r_o_right;
    assign o_res.heard_level   = w_heard_o;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    assign w_az_ok = (o_res.azimuth < DEG_360) && (o_res.left_azimuth < DEG_360) &&
                     (o_res.right_azimuth < DEG_360);
    assign w_el_ok = (o_res.elevation <= ELEV_LIM) && (o_res.elevation >= -ELEV_LIM);

    `ASSERT_IMP(a_ready_when_out_empty, i_clk, i_rst_n, !r_vld[ST_PC], i_src.ready)
    `ASSERT_NXT(a_accept_fills_stage0, i_clk, i_rst_n, i_src.valid && i_src.ready, r_vld[0])
    `ASSERT_IMP(a_angles_wrapped, i_clk, i_rst_n, o_res.valid, w_az_ok)
    `ASSERT_IMP(a_elev_in_range, i_clk, i_rst_n, o_res.valid, w_el_ok)

endmodule
